>>> sv/kgp_pkg.sv
// ----------------------------------------------------------------------------
// kgp_pkg
// Shared types, codes and defaults of the kerned glyph placer.
// ----------------------------------------------------------------------------
package kgp_pkg;

  localparam int KGP_GLYPH_COUNT   = 256;
  localparam int KGP_KERN_ROWS     = 32;
  localparam int KGP_ATLAS_COLUMNS = 31;

  localparam int KGP_INSET_W = 6;
  localparam int KGP_PROF_W  = 14;
  localparam int KGP_CAND_W  = KGP_PROF_W + 1;
  localparam int KGP_OFS_W   = 12;
  localparam int KGP_OUT_W   = 16;

  localparam logic [1:0] KGP_ACT_LOAD  = 2'd0;
  localparam logic [1:0] KGP_ACT_START = 2'd1;
  localparam logic [1:0] KGP_ACT_PLACE = 2'd2;

  localparam logic KGP_REG_X_OFFSET = 1'b0;
  localparam logic KGP_REG_Y_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    KGP_IDLE,
    KGP_FETCH,
    KGP_REDUCE,
    KGP_UPDATE
  } kgp_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } kgp_tree_ctl_t;

endpackage

>>> sv/kerned_glyph_placer.sv
// ----------------------------------------------------------------------------
// kerned_glyph_placer
// Places glyphs left to right against a per-row right-edge profile using
// per-glyph kern insets, and emits screen and atlas rectangles.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   input    | start / busy                 | in_action .. in_line_top_y
//   result   | out_valid (one-cycle strobe) | out_screen_* , out_tex_*
//   config   | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// load kern row and start line complete while idle; busy stays low.
// place glyph runs a kern memory read, a candidate load, one step per max tree
// level, then a profile update.
// the result strobes in the cycle after the update; a new transfer may be
// accepted in that same cycle.
// synchronous active-low reset clears the profile, line top, offsets and fsm;
// kern tables are not cleared.
// the receiver cannot stall results.
// ----------------------------------------------------------------------------
module kerned_glyph_placer import kgp_pkg::*; #(
  parameter int GLYPH_COUNT   = KGP_GLYPH_COUNT,
  parameter int KERN_ROWS     = KGP_KERN_ROWS,
  parameter int ATLAS_COLUMNS = KGP_ATLAS_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [7:0]             in_glyph,
  input  logic [4:0]             in_kern_row,
  input  logic [KGP_INSET_W-1:0] in_left_inset,
  input  logic [KGP_INSET_W-1:0] in_right_inset,
  input  logic [10:0]            in_line_start_x,
  input  logic [10:0]            in_line_top_y,
  output logic                   out_valid,
  output logic [KGP_OUT_W-1:0]   out_screen_x1,
  output logic [KGP_OUT_W-1:0]   out_screen_x2,
  output logic [KGP_OUT_W-1:0]   out_screen_y1,
  output logic [KGP_OUT_W-1:0]   out_screen_y2,
  output logic [KGP_OUT_W-1:0]   out_tex_u1,
  output logic [KGP_OUT_W-1:0]   out_tex_u2,
  output logic [KGP_OUT_W-1:0]   out_tex_v1,
  output logic [KGP_OUT_W-1:0]   out_tex_v2,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int GW    = $clog2(GLYPH_COUNT);
  localparam int RW    = $clog2(KERN_ROWS);
  localparam int LOG   = $clog2(KERN_ROWS);
  localparam int LVW   = $clog2(LOG + 1);
  localparam int RECIP = (1 << 16) / ATLAS_COLUMNS;

  kgp_state_t    state_r, state_nxt;
  kgp_tree_ctl_t tree_ctl;

  logic                 accept;
  logic                 glyph_ok;
  logic                 row_ok;
  logic                 mem_wr;
  logic                 mem_rd;
  logic                 line_set;
  logic                 upd;
  logic [LVW-1:0]       lvl_r;
  logic [7:0]           glyph_r;
  logic [7:0]           q_est_r;
  logic [7:0]           q_r;
  logic [7:0]           rem_r;
  logic [24:0]          q_prod;
  logic [15:0]          rem_raw;
  logic [10:0]          line_top_r;

  logic [KERN_ROWS-1:0][KGP_PROF_W-1:0]  prof_r;
  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] rd_left;
  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] rd_right;
  logic signed [KGP_CAND_W-1:0]          x_max;
  logic [KGP_OFS_W-1:0]                  x_offset;
  logic [KGP_OFS_W-1:0]                  y_offset;
  logic [KGP_OUT_W-1:0]                  x16;
  logic [KGP_OUT_W-1:0]                  xo;
  logic [KGP_OUT_W-1:0]                  yo;
  logic [KGP_OUT_W-1:0]                  sx1;
  logic [KGP_OUT_W-1:0]                  sy1;
  logic [KGP_OUT_W-1:0]                  tu1;
  logic [KGP_OUT_W-1:0]                  tv1;

  logic                 out_valid_r;
  logic [KGP_OUT_W-1:0] sx1_r, sx2_r, sy1_r, sy2_r, tu1_r, tu2_r, tv1_r, tv2_r;

  assign accept   = start && !busy;
  assign glyph_ok = {1'b0, in_glyph} < 9'(GLYPH_COUNT);
  assign row_ok   = {2'b0, in_kern_row} < 7'(KERN_ROWS);

  kgp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .x_offset (x_offset),
    .y_offset (y_offset)
  );

  kgp_kern_mem #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .KERN_ROWS   (KERN_ROWS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr),
    .rd_en    (mem_rd),
    .addr     (GW'(in_glyph)),
    .wr_row   (RW'(in_kern_row)),
    .wr_left  (in_left_inset),
    .wr_right (in_right_inset),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  kgp_max_tree #(
    .KERN_ROWS (KERN_ROWS)
  ) u_tree (
    .clk     (clk),
    .ctl     (tree_ctl),
    .prof    (prof_r),
    .left    (rd_left),
    .max_val (x_max)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KGP_IDLE: begin
        if (accept && in_action == KGP_ACT_PLACE && glyph_ok) state_nxt = KGP_FETCH;
      end
      KGP_FETCH:  state_nxt = KGP_REDUCE;
      KGP_REDUCE: begin
        if (lvl_r == LVW'(LOG - 1)) state_nxt = KGP_UPDATE;
      end
      KGP_UPDATE: state_nxt = KGP_IDLE;
      default:    state_nxt = KGP_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy          = 1'b1;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    line_set      = 1'b0;
    upd           = 1'b0;
    tree_ctl.load = 1'b0;
    tree_ctl.step = 1'b0;
    case (state_r)
      KGP_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_action)
            KGP_ACT_LOAD:  mem_wr   = glyph_ok && row_ok;
            KGP_ACT_START: line_set = 1'b1;
            KGP_ACT_PLACE: mem_rd   = glyph_ok;
            default: ;
          endcase
        end
      end
      KGP_FETCH:  tree_ctl.load = 1'b1;
      KGP_REDUCE: tree_ctl.step = 1'b1;
      KGP_UPDATE: upd = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KGP_IDLE;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == KGP_REDUCE) begin
        lvl_r <= lvl_r + LVW'(1);
      end else begin
        lvl_r <= '0;
      end
    end
  end

  // atlas cell: glyph / ATLAS_COLUMNS by reciprocal, then one correction
  assign q_prod  = 25'(glyph_r) * 25'(RECIP);
  assign rem_raw = 16'(glyph_r) - 16'(q_est_r) * 16'(ATLAS_COLUMNS);

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      glyph_r <= in_glyph;
    end
    if (state_r == KGP_FETCH) begin
      q_est_r <= q_prod[23:16];
    end
    if (state_r == KGP_REDUCE && lvl_r == '0) begin
      if (rem_raw >= 16'(ATLAS_COLUMNS)) begin
        q_r   <= q_est_r + 8'd1;
        rem_r <= 8'(rem_raw - 16'(ATLAS_COLUMNS));
      end else begin
        q_r   <= q_est_r;
        rem_r <= rem_raw[7:0];
      end
    end
  end

  // right-edge profile and line top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_r     <= '0;
      line_top_r <= '0;
    end else if (line_set) begin
      for (int r = 0; r < KERN_ROWS; r++) begin
        prof_r[r] <= KGP_PROF_W'(in_line_start_x);
      end
      line_top_r <= in_line_top_y;
    end else if (upd) begin
      for (int r = 0; r < KERN_ROWS; r++) begin
        prof_r[r] <= x_max[KGP_PROF_W-1:0] + KGP_PROF_W'(32)
                   - KGP_PROF_W'(rd_right[r]);
      end
    end
  end

  // result rectangles, 16-bit wrap
  assign x16 = KGP_OUT_W'(x_max);
  assign xo  = {x_offset, 4'b0};
  assign yo  = {y_offset, 4'b0};
  assign sx1 = {x16[11:0], 4'b0} + xo;
  assign sy1 = 16'({line_top_r, 3'b0}) + yo;
  assign tu1 = 16'({rem_r, 9'b0}) + xo;
  assign tv1 = 16'({q_r, 9'b0}) + 16'd16 + xo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      sx1_r <= sx1;
      sx2_r <= sx1 + 16'd512;
      sy1_r <= sy1;
      sy2_r <= sy1 + 16'd256;
      tu1_r <= tu1;
      tu2_r <= tu1 + 16'd512;
      tv1_r <= tv1;
      tv2_r <= tv1 + 16'd512;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_screen_x1 = sx1_r;
  assign out_screen_x2 = sx2_r;
  assign out_screen_y1 = sy1_r;
  assign out_screen_y2 = sy2_r;
  assign out_tex_u1    = tu1_r;
  assign out_tex_u2    = tu2_r;
  assign out_tex_v1    = tv1_r;
  assign out_tex_v2    = tv2_r;

  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == KGP_UPDATE))
    else $error("result strobe without a profile update");

  a_strobe_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_place_enters_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == KGP_ACT_PLACE && glyph_ok |=> state_r == KGP_FETCH)
    else $error("accepted placement did not start a kern read");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == KGP_REDUCE |-> lvl_r <= LVW'(LOG - 1))
    else $error("max tree level counter overran");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !mem_wr && !mem_rd && !line_set)
    else $error("state written while a placement is in flight");

endmodule

>>> sv/kgp_cfg_regs.sv
// ----------------------------------------------------------------------------
// kgp_cfg_regs
// APB register file holding the screen x and y offsets.
// ----------------------------------------------------------------------------
module kgp_cfg_regs import kgp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [KGP_OFS_W-1:0] x_offset,
  output logic [KGP_OFS_W-1:0] y_offset
);

  logic [KGP_OFS_W-1:0] x_offset_r;
  logic [KGP_OFS_W-1:0] y_offset_r;
  logic                 wr_xfer;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= '0;
      y_offset_r <= '0;
    end else if (wr_xfer) begin
      case (paddr[2])
        KGP_REG_X_OFFSET: x_offset_r <= pwdata[KGP_OFS_W-1:0];
        KGP_REG_Y_OFFSET: y_offset_r <= pwdata[KGP_OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      KGP_REG_X_OFFSET: prdata = {{(32-KGP_OFS_W){1'b0}}, x_offset_r};
      KGP_REG_Y_OFFSET: prdata = {{(32-KGP_OFS_W){1'b0}}, y_offset_r};
      default:          prdata = '0;
    endcase
  end

  assign x_offset = x_offset_r;
  assign y_offset = y_offset_r;

endmodule

>>> sv/kgp_kern_mem.sv
// ----------------------------------------------------------------------------
// kgp_kern_mem
// Kern inset tables, one word per glyph holding every row, row-masked writes.
// ----------------------------------------------------------------------------
module kgp_kern_mem import kgp_pkg::*; #(
  parameter int GLYPH_COUNT = KGP_GLYPH_COUNT,
  parameter int KERN_ROWS   = KGP_KERN_ROWS,
  localparam int GW = $clog2(GLYPH_COUNT),
  localparam int RW = $clog2(KERN_ROWS)
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic                                    rd_en,
  input  logic [GW-1:0]                           addr,
  input  logic [RW-1:0]                           wr_row,
  input  logic [KGP_INSET_W-1:0]                  wr_left,
  input  logic [KGP_INSET_W-1:0]                  wr_right,
  output logic [KERN_ROWS-1:0][KGP_INSET_W-1:0]   rd_left,
  output logic [KERN_ROWS-1:0][KGP_INSET_W-1:0]   rd_right
);

  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] left_mem  [GLYPH_COUNT];
  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] right_mem [GLYPH_COUNT];
  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] rd_left_r;
  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0] rd_right_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[addr][wr_row]  <= wr_left;
      right_mem[addr][wr_row] <= wr_right;
    end
    if (rd_en) begin
      rd_left_r  <= left_mem[addr];
      rd_right_r <= right_mem[addr];
    end
  end

  assign rd_left  = rd_left_r;
  assign rd_right = rd_right_r;

endmodule

>>> sv/kgp_max_tree.sv
// ----------------------------------------------------------------------------
// kgp_max_tree
// Row candidates (profile minus left inset) folded by a registered max tree,
// one level per step.
// ----------------------------------------------------------------------------
module kgp_max_tree import kgp_pkg::*; #(
  parameter int KERN_ROWS = KGP_KERN_ROWS,
  localparam int LOG = $clog2(KERN_ROWS),
  localparam int P   = 1 << LOG
) (
  input  logic                                   clk,
  input  kgp_tree_ctl_t                          ctl,
  input  logic [KERN_ROWS-1:0][KGP_PROF_W-1:0]   prof,
  input  logic [KERN_ROWS-1:0][KGP_INSET_W-1:0]  left,
  output logic signed [KGP_CAND_W-1:0]           max_val
);

  localparam logic signed [KGP_CAND_W-1:0] CAND_MIN = {1'b1, {(KGP_CAND_W-1){1'b0}}};

  logic signed [KGP_CAND_W-1:0] cand [P];
  logic signed [KGP_CAND_W-1:0] tree_r [P];

  for (genvar g = 0; g < P; g++) begin : g_cand
    if (g < KERN_ROWS) begin : g_row
      assign cand[g] = $signed({prof[g][KGP_PROF_W-1], prof[g]})
                     - $signed({{(KGP_CAND_W-KGP_INSET_W){1'b0}}, left[g]});
    end else begin : g_pad
      assign cand[g] = CAND_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < P; i++) begin
        tree_r[i] <= cand[i];
      end
    end else if (ctl.step) begin
      for (int i = 0; i < P / 2; i++) begin
        tree_r[i] <= (tree_r[2*i+1] > tree_r[2*i]) ? tree_r[2*i+1] : tree_r[2*i];
      end
    end
  end

  assign max_val = tree_r[0];

endmodule
